@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared forms for concurrent checks on clk, disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/m61rh_pkg.sv @@
// ---------------------------------------------------------------------------
// m61rh_pkg
// Widths, constants and helpers of the mod 2^61-1 rolling hash.
// ---------------------------------------------------------------------------
package m61rh_pkg;

	localparam int HASH_W = 61;
	localparam int LEN_W  = 31;        // bits of seg_len used
	localparam int LEN_PORT_W = 31;
	localparam int HALF_W = 31;        // low half of an operand
	localparam int HIGH_W = HASH_W - HALF_W;
	localparam int TDATA_W = ((HASH_W + LEN_PORT_W + 7) / 8) * 8;

	localparam logic [HASH_W-1:0] MOD_P     = {HASH_W{1'b1}};
	localparam logic [HASH_W-1:0] BASE_INIT = HASH_W'(10007);

	function automatic logic [HASH_W-1:0] red_p(input logic [HASH_W-1:0] x);
		return (x == MOD_P) ? '0 : x;
	endfunction

endpackage

@@ src/m61rh_mulmod.sv @@
// ---------------------------------------------------------------------------
// m61rh_mulmod
// Multi-cycle a*b mod 2^61-1 built on one 31x31 multiplier and Mersenne fold.
// ---------------------------------------------------------------------------
module m61rh_mulmod
	import m61rh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] op_a,
	input  logic [HASH_W-1:0] op_b,
	output logic              done,
	output logic [HASH_W-1:0] result
);

	logic              busy_q;
	logic [2:0]        ph_q;
	logic              done_q;
	logic [61:0]       prod_q;
	logic [61:0]       mid_q;
	logic [63:0]       r_q;
	logic [HASH_W-1:0] res_q;

	logic [HALF_W-1:0] mul_x, mul_y;
	logic [61:0]       prod;
	logic [61:0]       fold;
	logic [63:0]       r_sum;

	// partial product select: al*bl, ah*bl, al*bh, ah*bh
	always_comb begin
		case (ph_q)
			3'd0: begin
				mul_x = op_a[HALF_W-1:0];
				mul_y = op_b[HALF_W-1:0];
			end
			3'd1: begin
				mul_x = HALF_W'(op_a[HASH_W-1:HALF_W]);
				mul_y = op_b[HALF_W-1:0];
			end
			3'd2: begin
				mul_x = op_a[HALF_W-1:0];
				mul_y = HALF_W'(op_b[HASH_W-1:HALF_W]);
			end
			default: begin
				mul_x = HALF_W'(op_a[HASH_W-1:HALF_W]);
				mul_y = HALF_W'(op_b[HASH_W-1:HALF_W]);
			end
		endcase
	end

	assign prod  = 62'(mul_x) * 62'(mul_y);
	assign r_sum = r_q + {1'b0, prod_q, 1'b0} + 64'(mid_q[61:30])
		+ {3'b0, mid_q[29:0], 31'b0};
	assign fold  = 62'(r_q[63:61]) + 62'(r_q[60:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && !start && (ph_q == 3'd5);
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= '0;
			end else if (busy_q) begin
				if (ph_q == 3'd5)
					busy_q <= 1'b0;
				ph_q <= ph_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			prod_q <= prod;
			case (ph_q)
				3'd1: r_q   <= 64'(prod_q);
				3'd2: mid_q <= prod_q;
				3'd3: mid_q <= mid_q + prod_q;
				3'd4: r_q   <= r_sum;
				3'd5: res_q <= (fold >= 62'(MOD_P)) ? HASH_W'(fold - 62'(MOD_P))
					: HASH_W'(fold);
				default: ;
			endcase
		end
	end

	assign done   = done_q;
	assign result = res_q;

endmodule

@@ src/mersenne61_rolling_hash_concat.sv @@
// ---------------------------------------------------------------------------
// mersenne61_rolling_hash_concat
// Rolling hash mod 2^61-1: acc = acc*base^len + seg_hash, with running length.
// ---------------------------------------------------------------------------
// Work per item: a modular multiply is needed per set bit of seg_len,
// per squaring below its top set bit, and once more for acc*power.
// Throughput: one item at a time; the single 31x31 multiplier sets the
// pace and a stalled result holds the last step.
// Reset: arst_n clears hash and length to zero and sets hash_base to 10007.
module mersenne61_rolling_hash_concat
	import m61rh_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [HASH_W-1:0]  cfg_wdata,      // hash_base
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,   // seg_hash[60:0], seg_len[91:61]
	input  logic               s_axis_tuser,   // clear
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata    // acc_hash[60:0], acc_len[91:61]
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_BIT  = 6'b000010,
		S_MULR = 6'b000100,
		S_MULX = 6'b001000,
		S_MULA = 6'b010000,
		S_ADD  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [HASH_W-1:0] base_q;
	logic [HASH_W-1:0] acc_hash_q;
	logic [LEN_W-1:0]  acc_len_q;
	logic [HASH_W-1:0] h_q, sh_q, r_q, x_q;
	logic [LEN_W-1:0]  e_q;
	logic [HASH_W-1:0] op_a_q, op_b_q;
	logic              start_q;
	logic              out_valid_q;
	logic [HASH_W-1:0] out_hash_q;
	logic [LEN_W-1:0]  out_len_q;

	logic              mul_done;
	logic [HASH_W-1:0] mul_res;
	logic              in_xfer, out_free;
	logic [HASH_W-1:0] seg_hash_in;
	logic [LEN_W-1:0]  seg_len_in;
	logic [LEN_W:0]    len_sum;
	logic [HASH_W:0]   hsum;

	assign seg_hash_in = s_axis_tdata[HASH_W-1:0];
	assign seg_len_in  = s_axis_tdata[HASH_W +: LEN_W];
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign len_sum  = (s_axis_tuser ? '0 : {1'b0, acc_len_q}) + {1'b0, seg_len_in};
	assign hsum     = {1'b0, mul_res} + {1'b0, sh_q};

	m61rh_mulmod u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.op_a   (op_a_q),
		.op_b   (op_b_q),
		.done   (mul_done),
		.result (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			base_q      <= BASE_INIT;
			acc_hash_q  <= '0;
			acc_len_q   <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= (state_q == S_BIT);
			if (cfg_we)
				base_q <= red_p(cfg_wdata);
			if ((state_q == S_ADD) && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						acc_len_q <= len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];
						state_q   <= S_BIT;
					end
				end
				S_BIT: begin
					if (e_q == '0)
						state_q <= S_MULA;
					else if (e_q[0])
						state_q <= S_MULR;
					else
						state_q <= S_MULX;
				end
				S_MULR, S_MULX: begin
					if (mul_done)
						state_q <= S_BIT;
				end
				S_MULA: begin
					if (mul_done)
						state_q <= S_ADD;
				end
				S_ADD: begin
					// hold until the output register is free
					if (out_free) begin
						acc_hash_q  <= (hsum >= {1'b0, MOD_P}) ? HASH_W'(hsum - {1'b0, MOD_P})
							: hsum[HASH_W-1:0];
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					h_q  <= s_axis_tuser ? '0 : acc_hash_q;
					sh_q <= red_p(seg_hash_in);
					e_q  <= seg_len_in;
					r_q  <= HASH_W'(1);
					x_q  <= base_q;
				end
			end
			S_BIT: begin
				if (e_q == '0) begin
					op_a_q <= h_q;
					op_b_q <= r_q;
				end else if (e_q[0]) begin
					op_a_q <= r_q;
					op_b_q <= x_q;
				end else begin
					op_a_q <= x_q;
					op_b_q <= x_q;
				end
			end
			S_MULR: begin
				if (mul_done) begin
					r_q    <= mul_res;
					e_q[0] <= 1'b0;
				end
			end
			S_MULX: begin
				if (mul_done) begin
					x_q <= mul_res;
					e_q <= e_q >> 1;
				end
			end
			S_ADD: begin
				if (out_free) begin
					out_hash_q <= (hsum >= {1'b0, MOD_P}) ? HASH_W'(hsum - {1'b0, MOD_P})
						: hsum[HASH_W-1:0];
					out_len_q  <= acc_len_q;
				end
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'({LEN_PORT_W'(out_len_q), out_hash_q});

endmodule

@@ src/m61rh_checker.sv @@
// ---------------------------------------------------------------------------
// m61rh_checker
// Port-level checks on the rolling hash block, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module m61rh_checker
	import m61rh_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_we,
	input logic [HASH_W-1:0]  cfg_wdata,
	input logic               s_axis_tvalid,
	input logic               s_axis_tready,
	input logic [TDATA_W-1:0] s_axis_tdata,
	input logic               s_axis_tuser,
	input logic               m_axis_tvalid,
	input logic               m_axis_tready,
	input logic [TDATA_W-1:0] m_axis_tdata
);

	`AST_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
	`AST_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
	`AST_NEXT(a_no_early_out, s_axis_tvalid && s_axis_tready && !m_axis_tvalid, !m_axis_tvalid, "result before work done")
	`AST_IMPL(a_hash_reduced, m_axis_tvalid, m_axis_tdata[HASH_W-1:0] != MOD_P, "hash not reduced")

endmodule

bind mersenne61_rolling_hash_concat m61rh_checker u_m61rh_checker (.*);
